>>> sv/ppec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppec_pkg;

    localparam int MAX_POSITIONS_DEF = 1024;
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int QUEUE_DEPTH       = 2;
    localparam logic [31:0] MIN_ERRORS_RESET = 32'd100;

    typedef enum logic [1:0] {
        KIND_NOP  = 2'd0,
        KIND_CMP  = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    // classified item handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic        err;
        logic        ent_valid;
        logic        fend;
        logic        cleared;
        logic        clr_reach;
        logic [9:0]  pos;
        logic [15:0] clear_count;
    } t_ctl;

endpackage

`default_nettype wire

>>> sv/ppec_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ppec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/ppec_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ppec_front #(
    parameter int MAX_POSITIONS = ppec_pkg::MAX_POSITIONS_DEF,
    localparam int PW = $clog2(MAX_POSITIONS),
    localparam int LW = PW + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_operation,
    input  wire logic [7:0]    i_data_symbol,
    input  wire logic [7:0]    i_reference_symbol,
    input  wire logic [10:0]   i_frame_length,
    input  wire logic [9:0]    i_read_position,
    input  wire logic          i_q_ready,
    output logic               o_q_push,
    output ppec_pkg::t_ctl     o_q_ctl,
    output logic [PW-1:0]      o_q_addr,
    output logic [LW-1:0]      o_q_len
);

    logic [10:0] r_stored;
    logic [PW-1:0] r_cur;
    logic [LW-1:0] r_fill;
    logic [15:0] r_clears;

    logic [10:0] n_stored;
    logic [PW-1:0] n_cur;
    logic [LW-1:0] n_fill;
    logic [15:0] n_clears;

    logic len_ok;
    logic chg;
    logic fend;
    logic [PW-1:0] pos;
    logic [LW-1:0] fill_eff;

    assign o_ready  = i_q_ready;
    assign o_q_push = i_valid && i_q_ready;

    always_comb begin
        len_ok   = (i_frame_length != 11'd0) && (32'(i_frame_length) <= MAX_POSITIONS);
        chg      = i_frame_length != r_stored;
        pos      = chg ? '0 : r_cur;
        fill_eff = chg ? '0 : r_fill;
        fend     = (32'(pos) + 32'd1) >= 32'(i_frame_length);

        n_stored = r_stored;
        n_cur    = r_cur;
        n_fill   = r_fill;
        n_clears = r_clears;

        o_q_ctl             = '0;
        o_q_ctl.kind        = ppec_pkg::KIND_NOP;
        o_q_addr            = '0;
        o_q_len             = LW'(i_frame_length);

        if (i_operation) begin
            o_q_ctl.kind      = ppec_pkg::KIND_READ;
            o_q_addr          = PW'(i_read_position);
            o_q_ctl.ent_valid = (32'(i_read_position) < MAX_POSITIONS) &&
                                (32'(i_read_position) < 32'(r_fill));
        end else if (len_ok) begin
            if (chg) begin
                if (r_stored != 11'd0) begin
                    n_clears = r_clears + 16'd1;
                end
                n_stored = i_frame_length;
            end
            o_q_ctl.kind      = ppec_pkg::KIND_CMP;
            o_q_ctl.err       = i_data_symbol != i_reference_symbol;
            o_q_ctl.ent_valid = 32'(pos) < 32'(fill_eff);
            o_q_ctl.fend      = fend;
            o_q_ctl.cleared   = chg;
            o_q_ctl.clr_reach = chg && (r_stored != 11'd0);
            o_q_ctl.pos       = 10'(pos);
            o_q_addr          = pos;
            n_fill            = (32'(pos) == 32'(fill_eff)) ? fill_eff + LW'(1) : fill_eff;
            n_cur             = fend ? '0 : pos + PW'(1);
        end
        o_q_ctl.clear_count = n_clears;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= '0;
            r_cur    <= '0;
            r_fill   <= '0;
            r_clears <= '0;
        end else if (o_q_push) begin
            r_stored <= n_stored;
            r_cur    <= n_cur;
            r_fill   <= n_fill;
            r_clears <= n_clears;
        end
    end

    a_cur_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stored != 11'd0) |-> (32'(r_cur) < 32'(r_stored)))
        else $error("position beyond frame length");

    a_fill_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(r_stored))
        else $error("fill count beyond frame length");

endmodule

`default_nettype wire

>>> sv/ppec_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ppec_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ppec_pkg::QUEUE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_count;

    assign o_ready = 32'(r_count) < DEPTH;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/ppec_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ppec_back #(
    parameter int MAX_POSITIONS = ppec_pkg::MAX_POSITIONS_DEF,
    parameter int COUNT_WIDTH   = ppec_pkg::COUNT_WIDTH_DEF,
    localparam int PW = $clog2(MAX_POSITIONS),
    localparam int LW = PW + 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [31:0]    i_min_errors,
    input  wire logic           i_q_valid,
    output logic                o_q_pop,
    input  wire ppec_pkg::t_ctl i_q_ctl,
    input  wire logic [PW-1:0]  i_q_addr,
    input  wire logic [LW-1:0]  i_q_len,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_symbol_error,
    output logic [9:0]          o_position,
    output logic                o_frame_end,
    output logic                o_counters_cleared,
    output logic                o_min_reached,
    output logic [31:0]         o_read_count,
    output logic [15:0]         o_clear_count
);

    // execute stage (RAM data arrives here)
    logic           r_b2_valid;
    ppec_pkg::t_ctl r_b2_ctl;
    logic [PW-1:0]  r_b2_addr;
    logic [LW-1:0]  r_b2_len;
    logic           r_byp;
    logic [COUNT_WIDTH-1:0] r_byp_data;

    logic [LW-1:0]  r_pam;
    logic           r_reach;

    logic           r_out_valid;
    logic           r_out_err;
    logic [9:0]     r_out_pos;
    logic           r_out_fend;
    logic           r_out_cleared;
    logic           r_out_reach;
    logic [31:0]    r_out_rcount;
    logic [15:0]    r_out_clears;

    logic b2_fire;
    logic is_cmp;
    logic ram_we;
    logic hit;
    logic reach_new;
    logic [COUNT_WIDTH-1:0] rdata;
    logic [COUNT_WIDTH-1:0] old_c;
    logic [COUNT_WIDTH-1:0] new_c;
    logic [LW-1:0] pam_new;

    assign b2_fire = r_b2_valid && (!r_out_valid || i_ready);
    assign o_q_pop = i_q_valid && (!r_b2_valid || b2_fire);
    assign is_cmp  = r_b2_ctl.kind == ppec_pkg::KIND_CMP;
    assign ram_we  = b2_fire && is_cmp;

    ppec_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_POSITIONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_b2_addr),
        .i_wdata (new_c),
        .i_re    (o_q_pop),
        .i_raddr (i_q_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        old_c = '0;
        if (r_b2_ctl.ent_valid) begin
            old_c = r_byp ? r_byp_data : rdata;
        end
        new_c = old_c;
        if (is_cmp && r_b2_ctl.err && (old_c != '1)) begin
            new_c = old_c + COUNT_WIDTH'(1);
        end
        hit = is_cmp && r_b2_ctl.err &&
              (64'(old_c) < 64'(i_min_errors)) && (64'(new_c) >= 64'(i_min_errors));
        // saturates above any frame length
        pam_new = r_b2_ctl.cleared ? '0 : r_pam;
        if (hit && (pam_new != '1)) begin
            pam_new = pam_new + LW'(1);
        end
        reach_new = (r_b2_ctl.clr_reach ? 1'b0 : r_reach) ||
                    (r_b2_ctl.fend &&
                     ((i_min_errors == 32'd0) || (32'(pam_new) >= 32'(r_b2_len))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid  <= 1'b0;
            r_byp       <= 1'b0;
            r_pam       <= '0;
            r_reach     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_b2_valid <= 1'b1;
                r_byp      <= ram_we && (r_b2_addr == i_q_addr);
            end else if (b2_fire) begin
                r_b2_valid <= 1'b0;
                r_byp      <= 1'b0;
            end
            if (b2_fire) begin
                r_pam       <= pam_new;
                r_reach     <= reach_new;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b2_ctl   <= i_q_ctl;
            r_b2_addr  <= i_q_addr;
            r_b2_len   <= i_q_len;
            r_byp_data <= new_c;
        end
        if (b2_fire) begin
            r_out_err     <= r_b2_ctl.err;
            r_out_pos     <= r_b2_ctl.pos;
            r_out_fend    <= r_b2_ctl.fend;
            r_out_cleared <= r_b2_ctl.cleared;
            r_out_reach   <= reach_new;
            r_out_clears  <= r_b2_ctl.clear_count;
            case (r_b2_ctl.kind)
                ppec_pkg::KIND_READ: r_out_rcount <= 32'(old_c);
                default:             r_out_rcount <= 32'd0;
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_symbol_error     = r_out_err;
    assign o_position         = r_out_pos;
    assign o_frame_end        = r_out_fend;
    assign o_counters_cleared = r_out_cleared;
    assign o_min_reached      = r_out_reach;
    assign o_read_count       = r_out_rcount;
    assign o_clear_count      = r_out_clears;

    a_byp_with_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> r_b2_valid)
        else $error("bypass armed without an item in execute");

    a_reach_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_reach && !(b2_fire && r_b2_ctl.clr_reach)) |=> r_reach)
        else $error("reached flag dropped without a clear");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid)
        else $error("result beat dropped before acceptance");

endmodule

`default_nettype wire

>>> sv/per_position_error_counter.sv
// An accepted beat passes the queue, execute stage and output register to o_valid.
// Throughput: one item per cycle while i_ready is high, set by one counter RAM
// read-modify-write per item, with write-to-read forwarding for back-to-back items.
// Reset (synchronous, active low) clears control state and sets min_errors to 100;
// counter RAM is not swept, entries are qualified by a per-frame fill count.
`timescale 1ns / 1ps
`default_nettype none

module per_position_error_counter #(
    parameter int MAX_POSITIONS = ppec_pkg::MAX_POSITIONS_DEF,
    parameter int COUNT_WIDTH   = ppec_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_operation,
    input  wire logic [7:0]  i_data_symbol,
    input  wire logic [7:0]  i_reference_symbol,
    input  wire logic [10:0] i_frame_length,
    input  wire logic [9:0]  i_read_position,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_symbol_error,
    output logic [9:0]       o_position,
    output logic             o_frame_end,
    output logic             o_counters_cleared,
    output logic             o_min_reached,
    output logic [31:0]      o_read_count,
    output logic [15:0]      o_clear_count
);

    localparam int PW = $clog2(MAX_POSITIONS);
    localparam int LW = PW + 1;
    localparam int QW = $bits(ppec_pkg::t_ctl) + PW + LW;

    logic [31:0] r_min_errors;

    logic           f_push;
    logic           q_ready;
    ppec_pkg::t_ctl f_ctl;
    logic [PW-1:0]  f_addr;
    logic [LW-1:0]  f_len;
    logic [QW-1:0]  q_in;
    logic [QW-1:0]  q_out;
    logic           q_valid;
    logic           q_pop;
    ppec_pkg::t_ctl q_ctl;
    logic [PW-1:0]  q_addr;
    logic [LW-1:0]  q_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_errors <= ppec_pkg::MIN_ERRORS_RESET;
        end else if (i_cfg_we) begin
            r_min_errors <= i_cfg_wdata;
        end
    end

    ppec_front #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_data_symbol      (i_data_symbol),
        .i_reference_symbol (i_reference_symbol),
        .i_frame_length     (i_frame_length),
        .i_read_position    (i_read_position),
        .i_q_ready          (q_ready),
        .o_q_push           (f_push),
        .o_q_ctl            (f_ctl),
        .o_q_addr           (f_addr),
        .o_q_len            (f_len)
    );

    assign q_in = {f_ctl, f_addr, f_len};

    ppec_queue #(
        .WIDTH (QW),
        .DEPTH (ppec_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {q_ctl, q_addr, q_len} = q_out;

    ppec_back #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_min_errors       (r_min_errors),
        .i_q_valid          (q_valid),
        .o_q_pop            (q_pop),
        .i_q_ctl            (q_ctl),
        .i_q_addr           (q_addr),
        .i_q_len            (q_len),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_symbol_error     (o_symbol_error),
        .o_position         (o_position),
        .o_frame_end        (o_frame_end),
        .o_counters_cleared (o_counters_cleared),
        .o_min_reached      (o_min_reached),
        .o_read_count       (o_read_count),
        .o_clear_count      (o_clear_count)
    );

endmodule

`default_nettype wire

>>> verif/tb_per_position_error_counter.sv
`timescale 1ns / 1ps

module tb_per_position_error_counter;

    localparam int NPOS = ppec_pkg::MAX_POSITIONS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic OP_COMPARE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef struct {
        logic        op;
        logic [7:0]  sym;
        logic [7:0]  refsym;
        logic [10:0] flen;
        logic [9:0]  rpos;
    } t_sym_beat;

    typedef struct {
        logic        err;
        logic [9:0]  pos;
        logic        fend;
        logic        cleared;
        logic        reached;
        logic [31:0] rcount;
        logic [15:0] clears;
    } t_tally;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_operation = 1'b0;
    logic [7:0]  i_data_symbol = '0;
    logic [7:0]  i_reference_symbol = '0;
    logic [10:0] i_frame_length = '0;
    logic [9:0]  i_read_position = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_symbol_error;
    logic [9:0]  o_position;
    logic        o_frame_end;
    logic        o_counters_cleared;
    logic        o_min_reached;
    logic [31:0] o_read_count;
    logic [15:0] o_clear_count;

    per_position_error_counter dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_data_symbol      (i_data_symbol),
        .i_reference_symbol (i_reference_symbol),
        .i_frame_length     (i_frame_length),
        .i_read_position    (i_read_position),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_symbol_error     (o_symbol_error),
        .o_position         (o_position),
        .o_frame_end        (o_frame_end),
        .o_counters_cleared (o_counters_cleared),
        .o_min_reached      (o_min_reached),
        .o_read_count       (o_read_count),
        .o_clear_count      (o_clear_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] tally_count [NPOS];
    bit          tally_seen  [NPOS];
    logic [9:0]  frame_pos = '0;
    logic [10:0] frame_len = '0;
    int          at_min = 0;
    bit          reached = 1'b0;
    logic [15:0] clears = '0;
    logic [31:0] min_thr = ppec_pkg::MIN_ERRORS_RESET;

    t_sym_beat pending_beats [$];
    t_tally    expected_tallies [$];
    t_sym_beat cur_beat;
    t_tally    want;
    int        planned_beats = 0;
    int        fail_count = 0;
    int        cycles = 0;
    int        tx_gap = 0;
    int        rx_wait = 0;
    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;

    function automatic t_tally predict_tally(t_sym_beat b);
        t_tally r;
        logic [9:0] p;
        logic [31:0] oldc;
        logic [31:0] newc;
        r = '{default: '0};
        if (b.op == OP_READ) begin
            if (tally_seen[b.rpos]) r.rcount = tally_count[b.rpos];
        end else if (b.flen >= 1 && b.flen <= NPOS) begin
            if (b.flen != frame_len) begin
                if (frame_len != 0) begin
                    clears = clears + 16'd1;
                    reached = 1'b0;
                end
                foreach (tally_seen[k]) tally_seen[k] = 1'b0;
                frame_pos = '0;
                at_min = 0;
                frame_len = b.flen;
                r.cleared = 1'b1;
            end
            p = frame_pos;
            oldc = tally_seen[p] ? tally_count[p] : 32'd0;
            newc = oldc;
            if (b.sym != b.refsym) begin
                r.err = 1'b1;
                if (oldc != '1) newc = oldc + 32'd1;
                if (oldc < min_thr && newc >= min_thr) at_min++;
            end
            tally_count[p] = newc;
            tally_seen[p] = 1'b1;
            r.pos = p;
            if (int'(p) + 1 >= int'(frame_len)) begin
                r.fend = 1'b1;
                if (min_thr == 0 || at_min >= int'(frame_len)) reached = 1'b1;
                frame_pos = '0;
            end else begin
                frame_pos = p + 10'd1;
            end
        end
        r.reached = reached;
        r.clears = clears;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_val));
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_valid && o_ready) expected_tallies.push_back(predict_tally(cur_beat));
            if (!(i_valid && !o_ready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    cur_beat = pending_beats.pop_front();
                    i_operation <= cur_beat.op;
                    i_data_symbol <= cur_beat.sym;
                    i_reference_symbol <= cur_beat.refsym;
                    i_frame_length <= cur_beat.flen;
                    i_read_position <= cur_beat.rpos;
                    i_valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
                    tx_gap = tx_calm ? 0 : $urandom_range(0, 7);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_tallies.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_tallies.pop_front();
                    check_field("symbol_error", o_symbol_error, want.err);
                    check_field("position", o_position, want.pos);
                    check_field("frame_end", o_frame_end, want.fend);
                    check_field("counters_cleared", o_counters_cleared, want.cleared);
                    check_field("min_reached", o_min_reached, want.reached);
                    check_field("read_count", o_read_count, want.rcount);
                    check_field("clear_count", o_clear_count, want.clears);
                end
                if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_ready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_cmp(logic [7:0] sym, logic [7:0] refsym, logic [10:0] flen);
        t_sym_beat b;
        b.op = OP_COMPARE;
        b.sym = sym;
        b.refsym = refsym;
        b.flen = flen;
        b.rpos = 10'($urandom);
        pending_beats.push_back(b);
    endtask

    task automatic push_read(logic [9:0] rpos);
        t_sym_beat b;
        b.op = OP_READ;
        b.sym = 8'($urandom);
        b.refsym = 8'($urandom);
        b.flen = 11'($urandom);
        b.rpos = rpos;
        pending_beats.push_back(b);
    endtask

    // n beats at one frame length, with reads and bad-length noise mixed in
    task automatic push_run(int len, int n, int err_pct);
        int k;
        logic [7:0] s;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 3)
                push_cmp(8'($urandom), 8'($urandom),
                         ($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(1025, 2047)));
            if ($urandom_range(0, 99) < 8) begin
                if ($urandom_range(0, 1) == 0) push_read(10'($urandom_range(0, len - 1)));
                else push_read(10'($urandom));
            end else begin
                s = 8'($urandom);
                if ($urandom_range(0, 99) < err_pct)
                    push_cmp(s, s ^ 8'($urandom_range(1, 255)), 11'(len));
                else
                    push_cmp(s, s, 11'(len));
            end
            planned_beats++;
        end
    endtask

    task automatic random_runs(int target, int max_len, int err_pct);
        int start;
        int len;
        start = planned_beats;
        while (planned_beats - start < target) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, NPOS);
                push_run(len, $urandom_range(1, 12), err_pct);
            end else begin
                len = $urandom_range(1, max_len);
                push_run(len, $urandom_range(len, len * 12), err_pct);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || i_valid || expected_tallies.size() != 0)
            @(negedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_min_errors(logic [31:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        min_thr = v;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset threshold, no frame active yet
        push_read(10'd0);
        push_read(10'd1023);
        push_cmp(8'h12, 8'h34, 11'd0);
        push_cmp(8'hFF, 8'h00, 11'd2047);
        push_cmp(8'h00, 8'h01, 11'd1025);
        push_cmp(8'h00, 8'h00, 11'd1);
        push_cmp(8'hFF, 8'h00, 11'd1);
        push_cmp(8'hAA, 8'h55, 11'd1);
        push_read(10'd0);
        push_cmp(8'hFF, 8'hFF, 11'd1024);
        push_cmp(8'h00, 8'hFF, 11'd1024);
        push_cmp(8'h01, 8'h02, 11'd1024);
        push_read(10'd1);
        push_read(10'd2);
        push_read(10'd1023);
        push_read(10'd512);
        push_cmp(8'h03, 8'h03, 11'd512);
        push_cmp(8'h80, 8'h00, 11'd3);
        push_cmp(8'h7F, 8'h7F, 11'd3);
        push_cmp(8'h01, 8'h00, 11'd3);
        push_read(10'd0);
        push_read(10'd2);
        push_cmp(8'h55, 8'hAA, 11'd0);
        push_read(10'd0);

        // zero threshold: any frame end sets the flag
        set_min_errors(32'd0);
        push_cmp(8'h05, 8'h05, 11'd2);
        push_cmp(8'h05, 8'h05, 11'd2);
        push_cmp(8'h09, 8'h05, 11'd3);
        random_runs(40, 4, 50);

        set_min_errors(32'd1);
        random_runs(110, 6, 70);

        set_min_errors(32'd3);
        random_runs(110, 5, 85);

        set_min_errors(32'hFFFF_FFFF);
        random_runs(60, 16, 50);

        // lowered threshold keeps earlier counts
        set_min_errors(32'd2);
        random_runs(90, 8, 60);

        set_min_errors(ppec_pkg::MIN_ERRORS_RESET);
        push_run(1, 110, 100);
        random_runs(60, 8, 50);

        wait_drained();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
sv/ppec_pkg.sv
sv/ppec_ram.sv
sv/ppec_front.sv
sv/ppec_queue.sv
sv/ppec_back.sv
sv/per_position_error_counter.sv
verif/tb_per_position_error_counter.sv
